>>> hw/rtl/mtt_pkg.sv
// Shared types, codes and helpers for the multi timer table.
// No dependencies; imported by mtt_slot_store and multi_timer_table.
package mtt_pkg;

   localparam int TIME_W     = 48;
   localparam int IVAL_W     = 32;
   localparam int HANDLE_W   = 8;
   localparam int OP_W       = 3;

   // Fired notices per tick are capped; further due slots wait for the next tick.
   localparam int MAX_FIRES  = 16;
   localparam int FIRE_CW    = $clog2(MAX_FIRES + 1);
   localparam int FIRE_IW    = $clog2(MAX_FIRES);

   localparam logic [OP_W-1:0] OP_SET_ABS = 3'd0;
   localparam logic [OP_W-1:0] OP_SET_REL = 3'd1;
   localparam logic [OP_W-1:0] OP_UPDATE  = 3'd2;
   localparam logic [OP_W-1:0] OP_DELETE  = 3'd3;
   localparam logic [OP_W-1:0] OP_TICK    = 3'd4;

   localparam logic RESULT_FIRED   = 1'b0;
   localparam logic RESULT_SUMMARY = 1'b1;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [TIME_W-1:0]   deadline;
      logic [IVAL_W-1:0]   interval;
   } slot_entry_type;

   // Saturating 48-bit add.
   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
   endfunction

endpackage

>>> hw/rtl/mtt_slot_store.sv
// Slot entry store: handle, deadline and interval per slot.
// One write port, one read port with registered read data. Uses mtt_pkg.
module mtt_slot_store #(
   parameter int SLOTS = 16,
   parameter int IW    = 4
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [IW-1:0]           wr_addr,
   input  mtt_pkg::slot_entry_type wr_data,
   input  logic [IW-1:0]           rd_addr,
   output mtt_pkg::slot_entry_type rd_data
);
   import mtt_pkg::*;

   slot_entry_type mem [SLOTS];
   slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/multi_timer_table.sv
// Multi timer table: SLOTS timer slots with set, update, delete and tick items.
// Each item is accepted, every slot is then scanned through read, calc and fold states,
// the wait time is formed, then fired notices and the summary follow, one per cycle when rsp_stall is low.
// One item at a time; the scan is bound by the slot store's one read port and one shared adder.
// Reset (synchronous): all slots invalid, sequencer idle, no result pending.
module multi_timer_table #(
   parameter int SLOTS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [mtt_pkg::OP_W-1:0]       req_operation,
   input  logic [mtt_pkg::TIME_W-1:0]     req_current_time,
   input  logic [mtt_pkg::HANDLE_W-1:0]   req_handle,
   input  logic [mtt_pkg::TIME_W-1:0]     req_deadline_or_delay,
   input  logic [mtt_pkg::IVAL_W-1:0]     req_interval_ms,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_result_kind,
   output logic [mtt_pkg::HANDLE_W-1:0]   rsp_fired_handle,
   output logic                           rsp_last_result,
   output logic                           rsp_timer_armed,
   output logic [mtt_pkg::TIME_W-1:0]     rsp_wait_ms,
   output logic                           rsp_table_full
);
   import mtt_pkg::*;

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RD   = 3'd1;   // slot read in flight
   localparam logic [2:0] ST_CALC = 3'd2;   // match, due test, saturating add
   localparam logic [2:0] ST_FOLD = 3'd3;   // write back, fold into minimum
   localparam logic [2:0] ST_WAIT = 3'd4;   // wait time from earliest deadline
   localparam logic [2:0] ST_EMIT = 3'd5;   // drain notices, then summary

   logic [2:0]          state_ff, state_in;
   logic [CW-1:0]       idx_ff, idx_in;

   // latched request item
   logic [OP_W-1:0]     op_ff, op_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic [HANDLE_W-1:0] h_ff, h_in;
   logic [TIME_W-1:0]   dd_ff, dd_in;
   logic [IVAL_W-1:0]   iv_ff, iv_in;

   logic [SLOTS-1:0]    valid_ff, valid_in;

   // per-item accumulators
   logic                placed_ff, placed_in;
   logic                armed_ff, armed_in;
   logic [TIME_W-1:0]   next_ff, next_in;
   logic [FIRE_CW-1:0]  nf_ff, nf_in;
   logic [HANDLE_W-1:0] fired_ff [MAX_FIRES];
   logic                fire_wr;
   logic [TIME_W-1:0]   wait_ff, wait_in;
   logic [FIRE_CW-1:0]  ecnt_ff, ecnt_in;

   // per-slot scan results
   logic                cur_valid_ff, cur_valid_in;
   logic                match_ff, match_in;
   logic                due_ff, due_in;
   logic [TIME_W-1:0]   sum_ff, sum_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_load;
   logic                kind_ff, last_ff, armed_out_ff, full_ff;
   logic [HANDLE_W-1:0] handle_out_ff;
   logic [TIME_W-1:0]   wait_out_ff;
   logic                kind_in, last_in, full_in;
   logic [HANDLE_W-1:0] handle_out_in;

   // slot store
   logic                wr_en;
   slot_entry_type      wr_data, rd_data;
   logic [IW-1:0]       slot_addr;
   logic [TIME_W-1:0]   add_b;
   logic                new_valid;
   logic [TIME_W-1:0]   new_deadline;
   logic                is_set;

   assign slot_addr = idx_ff[IW-1:0];
   assign is_set    = (op_ff == OP_SET_ABS) || (op_ff == OP_SET_REL);

   mtt_slot_store #(
      .SLOTS (SLOTS),
      .IW    (IW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_addr),
      .wr_data (wr_data),
      .rd_addr (slot_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);

   // shared adder operand: relative delay on a relative set, the reload interval otherwise
   assign add_b = (op_ff == OP_SET_REL) ? dd_ff : {{(TIME_W-IVAL_W){1'b0}}, rd_data.interval};

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      op_in         = op_ff;
      now_in        = now_ff;
      h_in          = h_ff;
      dd_in         = dd_ff;
      iv_in         = iv_ff;
      valid_in      = valid_ff;
      placed_in     = placed_ff;
      armed_in      = armed_ff;
      next_in       = next_ff;
      nf_in         = nf_ff;
      fire_wr       = 1'b0;
      wait_in       = wait_ff;
      ecnt_in       = ecnt_ff;
      cur_valid_in  = cur_valid_ff;
      match_in      = match_ff;
      due_in        = due_ff;
      sum_in        = sum_ff;
      wr_en         = 1'b0;
      wr_data       = rd_data;
      new_valid     = cur_valid_ff;
      new_deadline  = rd_data.deadline;
      rsp_load      = 1'b0;
      kind_in       = RESULT_FIRED;
      last_in       = 1'b0;
      full_in       = 1'b0;
      handle_out_in = '0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in     = req_operation;
               now_in    = req_current_time;
               h_in      = req_handle;
               dd_in     = req_deadline_or_delay;
               iv_in     = req_interval_ms;
               idx_in    = '0;
               placed_in = 1'b0;
               armed_in  = 1'b0;
               next_in   = '0;
               nf_in     = '0;
               state_in  = ST_RD;
            end
         end
         ST_RD: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            cur_valid_in = valid_ff[slot_addr];
            match_in     = cur_valid_in && (rd_data.handle == h_ff);
            due_in       = cur_valid_in && (op_ff == OP_TICK)
                           && (rd_data.deadline <= now_ff)
                           && (nf_ff < FIRE_CW'(MAX_FIRES));
            sum_in       = sat_add(now_ff, add_b);
            state_in     = ST_FOLD;
         end
         ST_FOLD: begin
            if (is_set && !placed_ff && !cur_valid_ff) begin
               // lowest free slot takes the new timer
               wr_en            = 1'b1;
               wr_data.handle   = h_ff;
               wr_data.deadline = (op_ff == OP_SET_ABS) ? dd_ff : sum_ff;
               wr_data.interval = iv_ff;
               new_valid        = 1'b1;
               new_deadline     = wr_data.deadline;
               placed_in        = 1'b1;
            end else if ((op_ff == OP_UPDATE) && match_ff) begin
               wr_en            = 1'b1;
               wr_data.interval = iv_ff;
            end else if ((op_ff == OP_DELETE) && match_ff) begin
               new_valid = 1'b0;
            end else if (due_ff) begin
               fire_wr = 1'b1;
               nf_in   = nf_ff + 1'b1;
               if (rd_data.interval != '0) begin
                  wr_en            = 1'b1;
                  wr_data.deadline = sum_ff;
                  new_deadline     = sum_ff;
               end else begin
                  new_valid = 1'b0;   // one-shot frees itself
               end
            end
            valid_in[slot_addr] = new_valid;
            if (new_valid) begin
               if (!armed_ff || (new_deadline < next_ff)) begin
                  next_in = new_deadline;
               end
               armed_in = 1'b1;
            end
            if (idx_ff == CW'(SLOTS - 1)) begin
               state_in = ST_WAIT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_RD;
            end
         end
         ST_WAIT: begin
            if (!armed_ff) begin
               wait_in = '0;
            end else if (next_ff > now_ff) begin
               wait_in = next_ff - now_ff;
            end else begin
               wait_in = TIME_W'(1);
            end
            ecnt_in  = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               if (ecnt_ff == nf_ff) begin
                  kind_in  = RESULT_SUMMARY;
                  last_in  = 1'b1;
                  full_in  = is_set && !placed_ff;
                  state_in = ST_IDLE;
               end else begin
                  handle_out_in = fired_ff[ecnt_ff[FIRE_IW-1:0]];
                  ecnt_in       = ecnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      op_ff        <= op_in;
      now_ff       <= now_in;
      h_ff         <= h_in;
      dd_ff        <= dd_in;
      iv_ff        <= iv_in;
      placed_ff    <= placed_in;
      armed_ff     <= armed_in;
      next_ff      <= next_in;
      nf_ff        <= nf_in;
      wait_ff      <= wait_in;
      ecnt_ff      <= ecnt_in;
      cur_valid_ff <= cur_valid_in;
      match_ff     <= match_in;
      due_ff       <= due_in;
      sum_ff       <= sum_in;
      if (fire_wr) begin
         fired_ff[nf_ff[FIRE_IW-1:0]] <= rd_data.handle;
      end
      if (rsp_load) begin
         kind_ff       <= kind_in;
         last_ff       <= last_in;
         full_ff       <= full_in;
         handle_out_ff <= handle_out_in;
         armed_out_ff  <= armed_ff;
         wait_out_ff   <= wait_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = kind_ff;
   assign rsp_fired_handle = handle_out_ff;
   assign rsp_last_result  = last_ff;
   assign rsp_timer_armed  = armed_out_ff;
   assign rsp_wait_ms      = wait_out_ff;
   assign rsp_table_full   = full_ff;

endmodule

>>> verif/timer_table_checker.sv
// Scoreboard for multi_timer_table: watches both channels, keeps its own slot table,
// predicts every result and compares the results in order.
// Depends on mtt_pkg for field widths, operation codes and result kinds.
module timer_table_checker #(
   parameter int SLOTS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [mtt_pkg::OP_W-1:0]     req_operation,
   input  logic [mtt_pkg::TIME_W-1:0]   req_current_time,
   input  logic [mtt_pkg::HANDLE_W-1:0] req_handle,
   input  logic [mtt_pkg::TIME_W-1:0]   req_deadline_or_delay,
   input  logic [mtt_pkg::IVAL_W-1:0]   req_interval_ms,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic                         rsp_result_kind,
   input  logic [mtt_pkg::HANDLE_W-1:0] rsp_fired_handle,
   input  logic                         rsp_last_result,
   input  logic                         rsp_timer_armed,
   input  logic [mtt_pkg::TIME_W-1:0]   rsp_wait_ms,
   input  logic                         rsp_table_full,
   output int                           fail_count,
   output int                           pending_count,
   output int                           items_seen,
   output int                           results_seen,
   output int                           fired_seen,
   output int                           full_seen
);
   import mtt_pkg::*;

   typedef struct {
      logic                kind;
      logic [HANDLE_W-1:0] handle;
      logic                last;
      logic                armed;
      logic [TIME_W-1:0]   wait_time;
      logic                full;
   } timer_result_type;

   timer_result_type expected_results[$];

   // shadow slot table
   logic                timer_live     [SLOTS];
   logic [HANDLE_W-1:0] timer_owner    [SLOTS];
   logic [TIME_W-1:0]   timer_deadline [SLOTS];
   logic [IVAL_W-1:0]   timer_reload   [SLOTS];

   initial begin
      fail_count    = 0;
      pending_count = 0;
      items_seen    = 0;
      results_seen  = 0;
      fired_seen    = 0;
      full_seen     = 0;
   end

   task automatic report_mismatch(input string what, input longint unsigned exp_v,
                                  input longint unsigned got_v);
      $display("MISMATCH %s: expected 0x%0h, got 0x%0h", what, exp_v, got_v);
      fail_count++;
   endtask

   function automatic logic [TIME_W-1:0] clamp_add(input logic [TIME_W-1:0] a,
                                                   input logic [TIME_W-1:0] b);
      logic [TIME_W:0] total;
      total = {1'b0, a} + {1'b0, b};
      if (total[TIME_W])
         return {TIME_W{1'b1}};
      return total[TIME_W-1:0];
   endfunction

   // Apply one item to the shadow table and queue the results it produces.
   function automatic void predict_timer_item(input logic [OP_W-1:0]     op,
                                              input logic [TIME_W-1:0]   now,
                                              input logic [HANDLE_W-1:0] owner,
                                              input logic [TIME_W-1:0]   dd,
                                              input logic [IVAL_W-1:0]   reload);
      int                  free_idx;
      int                  nfire;
      logic [HANDLE_W-1:0] fired [MAX_FIRES];
      logic                full;
      logic                armed;
      logic [TIME_W-1:0]   earliest;
      logic [TIME_W-1:0]   wait_v;
      timer_result_type    r;
      free_idx = -1;
      nfire    = 0;
      full     = 1'b0;
      armed    = 1'b0;
      earliest = '0;
      wait_v   = '0;
      case (op)
         OP_SET_ABS, OP_SET_REL: begin
            for (int i = SLOTS - 1; i >= 0; i--)
               if (!timer_live[i])
                  free_idx = i;
            if (free_idx < 0) begin
               full = 1'b1;
            end else begin
               timer_live[free_idx]     = 1'b1;
               timer_owner[free_idx]    = owner;
               timer_deadline[free_idx] = (op == OP_SET_ABS) ? dd : clamp_add(now, dd);
               timer_reload[free_idx]   = reload;
            end
         end
         OP_UPDATE: begin
            for (int i = 0; i < SLOTS; i++)
               if (timer_live[i] && timer_owner[i] == owner)
                  timer_reload[i] = reload;
         end
         OP_DELETE: begin
            for (int i = 0; i < SLOTS; i++)
               if (timer_live[i] && timer_owner[i] == owner)
                  timer_live[i] = 1'b0;
         end
         OP_TICK: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (nfire < MAX_FIRES && timer_live[i] && timer_deadline[i] <= now) begin
                  fired[nfire] = timer_owner[i];
                  nfire++;
                  if (timer_reload[i] != '0)
                     timer_deadline[i] = clamp_add(now, {{(TIME_W-IVAL_W){1'b0}},
                                                         timer_reload[i]});
                  else
                     timer_live[i] = 1'b0;
               end
            end
         end
         default: ;
      endcase
      for (int i = 0; i < SLOTS; i++) begin
         if (timer_live[i]) begin
            if (!armed || timer_deadline[i] < earliest)
               earliest = timer_deadline[i];
            armed = 1'b1;
         end
      end
      if (armed)
         wait_v = (earliest > now) ? earliest - now : 48'd1;
      for (int k = 0; k < nfire; k++) begin
         r = '{RESULT_FIRED, fired[k], 1'b0, armed, wait_v, 1'b0};
         expected_results = {expected_results, r};
      end
      r = '{RESULT_SUMMARY, '0, 1'b1, armed, wait_v, full};
      expected_results = {expected_results, r};
   endfunction

   always @(posedge clock) begin
      timer_result_type e;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++)
            timer_live[i] = 1'b0;
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing expected, kind", '0,
                               64'(rsp_result_kind));
            end else begin
               e = expected_results.pop_front();
               if (e.kind == RESULT_FIRED)
                  fired_seen++;
               if (e.full)
                  full_seen++;
               if (rsp_result_kind !== e.kind)
                  report_mismatch("result_kind", 64'(e.kind), 64'(rsp_result_kind));
               if (rsp_fired_handle !== e.handle)
                  report_mismatch("fired_handle", 64'(e.handle), 64'(rsp_fired_handle));
               if (rsp_last_result !== e.last)
                  report_mismatch("last_result", 64'(e.last), 64'(rsp_last_result));
               if (rsp_timer_armed !== e.armed)
                  report_mismatch("timer_armed", 64'(e.armed), 64'(rsp_timer_armed));
               if (rsp_wait_ms !== e.wait_time)
                  report_mismatch("wait_ms", 64'(e.wait_time), 64'(rsp_wait_ms));
               if (rsp_table_full !== e.full)
                  report_mismatch("table_full", 64'(e.full), 64'(rsp_table_full));
            end
         end
         if (req_valid && !req_stall) begin
            items_seen++;
            predict_timer_item(req_operation, req_current_time, req_handle,
                               req_deadline_or_delay, req_interval_ms);
         end
      end
      pending_count = expected_results.size();
   end

endmodule

>>> verif/tb_top.sv
// Top of the multi_timer_table testbench: clock, reset, item stimulus and verdict.
// Depends on mtt_pkg, multi_timer_table and timer_table_checker.
module tb_top;
   import mtt_pkg::*;

   localparam int SLOTS        = 16;
   localparam int RANDOM_ITEMS = 85;
   // slowest item: a full scan plus 17 results, each possibly held back by receiver stalls
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 60;
   // codes past tick are undefined and must leave the table alone
   localparam logic [OP_W-1:0] OP_FIRST_RESERVED = OP_TICK + 3'd1;
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
   localparam logic [IVAL_W-1:0] IVAL_MAX = {IVAL_W{1'b1}};

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [OP_W-1:0]     req_operation;
   logic [TIME_W-1:0]   req_current_time;
   logic [HANDLE_W-1:0] req_handle;
   logic [TIME_W-1:0]   req_deadline_or_delay;
   logic [IVAL_W-1:0]   req_interval_ms;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_result_kind;
   logic [HANDLE_W-1:0] rsp_fired_handle;
   logic                rsp_last_result;
   logic                rsp_timer_armed;
   logic [TIME_W-1:0]   rsp_wait_ms;
   logic                rsp_table_full;

   int fail_count;
   int pending_count;
   int items_seen;
   int results_seen;
   int fired_seen;
   int full_seen;
   int cycle_count = 0;
   int burst_left  = 0;

   multi_timer_table #(.SLOTS(SLOTS)) i_dut (.*);

   timer_table_checker #(.SLOTS(SLOTS)) i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still owed", cycle_count,
                  pending_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Receiver back-pressure: switches between no stall, coin-flip stall and a
   // periodic stall, each for a random stretch of cycles.
   initial begin
      stall_mode_type mode;
      int             run;
      int             period;
      int             phase;
      rsp_stall = 1'b0;
      phase     = 0;
      forever begin
         mode   = stall_mode_type'($urandom_range(0, 2));
         run    = $urandom_range(20, 150);
         period = $urandom_range(2, 5);
         repeat (run) begin
            @(negedge clock);
            phase++;
            case (mode)
               STALL_NONE:     rsp_stall <= 1'b0;
               STALL_RANDOM:   rsp_stall <= ($urandom_range(0, 1) == 1);
               STALL_PERIODIC: rsp_stall <= (phase % period != 0);
               default:        rsp_stall <= 1'b0;
            endcase
         end
      end
   end

   function automatic logic [TIME_W-1:0] random_time();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[TIME_W-1:0];
   endfunction

   // Most items go to a few owners so update and delete actually hit slots.
   function automatic logic [HANDLE_W-1:0] pick_owner();
      if ($urandom_range(0, 9) < 7)
         return HANDLE_W'($urandom_range(0, 5));
      return HANDLE_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [IVAL_W-1:0] pick_reload();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 5)
         return '0;
      if (sel < 9)
         return IVAL_W'($urandom_range(1, 50));
      return $urandom;
   endfunction

   // Called at a falling edge; returns at the falling edge after the item is taken.
   // The sender runs in bursts; between bursts it drops valid for a few cycles.
   task automatic send_item(input logic [OP_W-1:0]     op,
                            input logic [TIME_W-1:0]   now,
                            input logic [HANDLE_W-1:0] owner,
                            input logic [TIME_W-1:0]   dd,
                            input logic [IVAL_W-1:0]   reload);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 8);
      end
      req_valid             <= 1'b1;
      req_operation         <= op;
      req_current_time      <= now;
      req_handle            <= owner;
      req_deadline_or_delay <= dd;
      req_interval_ms       <= reload;
      do
         @(posedge clock);
      while (req_stall);
      burst_left--;
      @(negedge clock);
   endtask

   // Hold off the sender until every owed result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0)
         @(negedge clock);
      burst_left = 0;
   endtask

   initial begin
      logic [TIME_W-1:0]   now_ms;
      logic [TIME_W-1:0]   dd;
      logic [OP_W-1:0]     op;
      logic [HANDLE_W-1:0] owner;
      int                  sel;
      reset                 <= 1'b1;
      req_valid             <= 1'b0;
      req_operation         <= OP_TICK;
      req_current_time      <= '0;
      req_handle            <= '0;
      req_deadline_or_delay <= '0;
      req_interval_ms       <= '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // undefined codes on an empty table
      for (int k = 0; k < 3; k++)
         send_item(OP_FIRST_RESERVED + 3'(k), random_time(), pick_owner(), random_time(),
                   $urandom);
      // relative set that saturates, with top handle and widest interval
      send_item(OP_SET_REL, TIME_MAX, 8'hFF, TIME_MAX, IVAL_MAX);
      // absolute set at time zero, handle zero, one-shot
      send_item(OP_SET_ABS, '0, 8'h00, '0, '0);
      // fill the remaining fourteen slots, mixing one-shot and periodic
      for (int k = 0; k < SLOTS - 2; k++)
         send_item(OP_SET_ABS, 48'd100, HANDLE_W'(k + 1), 48'(k * 10),
                   (k % 3 == 0) ? '0 : IVAL_W'(k + 1));
      // table is full now
      send_item(OP_SET_REL, 48'd100, 8'h42, 48'd5, 32'd7);
      // handle zero becomes periodic
      send_item(OP_UPDATE, 48'd100, 8'h00, '0, 32'd5);
      // delete with no matching slot
      send_item(OP_DELETE, 48'd100, 8'hC8, '0, '0);
      // everything is due: sixteen notices in one tick
      send_item(OP_TICK, TIME_MAX, 8'h00, '0, '0);
      send_item(OP_DELETE, TIME_MAX, 8'hFF, '0, '0);
      send_item(OP_TICK, '0, 8'h00, '0, '0);
      drain_results();

      // ---- random part ----
      now_ms = 48'($urandom_range(0, 1000000));
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         sel = $urandom_range(0, 99);
         if ($urandom_range(0, 99) < 3)
            now_ms = random_time();
         else
            now_ms = now_ms + 48'($urandom_range(0, 40));
         owner = pick_owner();
         if (sel < 22) begin
            dd = ($urandom_range(0, 9) == 0) ? random_time() : 48'($urandom_range(0, 100));
            send_item(OP_SET_REL, now_ms, owner, dd, pick_reload());
         end else if (sel < 42) begin
            case ($urandom_range(0, 9))
               0:       dd = random_time();
               1, 2:    dd = now_ms - 48'($urandom_range(0, 30));
               default: dd = now_ms + 48'($urandom_range(0, 100));
            endcase
            send_item(OP_SET_ABS, now_ms, owner, dd, pick_reload());
         end else if (sel < 72) begin
            send_item(OP_TICK, now_ms, owner, random_time(), $urandom);
         end else if (sel < 80) begin
            send_item(OP_UPDATE, now_ms, owner, random_time(), pick_reload());
         end else if (sel < 90) begin
            send_item(OP_DELETE, now_ms, owner, random_time(), $urandom);
         end else if (sel < 94) begin
            send_item(OP_FIRST_RESERVED + 3'($urandom_range(0, 2)), now_ms, owner,
                      random_time(), $urandom);
         end else begin
            // noise: any code, fields over their whole range
            op = OP_W'($urandom_range(0, 7));
            send_item(op, random_time(), HANDLE_W'($urandom), random_time(), $urandom);
         end
         if (n % 37 == 36)
            drain_results();
      end

      req_valid <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d items and %0d results: %0d fired notices, %0d full-table sets.",
               items_seen, results_seen, fired_seen, full_seen);
      $display("Mismatches: %0d, results still owed: %0d", fail_count, pending_count);
      if (fail_count == 0 && pending_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> multi_timer_table.f
hw/rtl/mtt_pkg.sv
hw/rtl/mtt_slot_store.sv
hw/rtl/multi_timer_table.sv
verif/timer_table_checker.sv
verif/tb_top.sv
